// ===== rtl/core/shp_pkg.sv =====
// Shared constants, codes and types of the 3x3 sharpening stream block.
package shp_pkg;

  localparam int PIX_W       = 8;
  localparam int ROW_W       = 12;
  localparam int OUT_INDEX_W = 13;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ROW_W-1:0] row_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

  localparam logic [CFG_W-1:0] COLUMNS_RST  = 12'd640;
  localparam logic [CFG_W-1:0] ROWS_RST     = 12'd480;
  localparam logic [2:0]       CHANNELS_RST = 3'd1;

  localparam row_t ROWS_MIN = 12'd3;
  localparam row_t COLS_MIN = 12'd3;

  // What one item produces on the output side.
  typedef enum logic [1:0] {
    RES_ZERO_ROW,  // first row: a single zero result
    RES_NONE,      // second row: stored only
    RES_BODY,      // one sharpened result for the row above
    RES_LAST_ROW   // sharpened result for the row above, then a zero result
  } shp_res_e;

  // Control and position of the item in the kernel stage.
  typedef struct packed {
    logic step;       // item leaves the kernel stage this cycle
    logic [15:0] idx; // component index within the row, zero extended
  } shp_kctl_t;

endpackage

// ===== rtl/core/shp_kernel.sv =====
// Cross kernel arithmetic with the per-channel left neighbour store.
module shp_kernel #(
  parameter int MAX_CHANNELS = 4,
  parameter int AW           = 13,
  parameter int LW           = 14,
  parameter int HW           = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  shp_pkg::shp_kctl_t ctl_i,
  input  logic [LW-1:0]      len_i,
  input  logic [HW-1:0]      chans_i,
  input  shp_pkg::pix_t      pixel_i,
  input  shp_pkg::pix_t      centre_i,
  input  shp_pkg::pix_t      right_i,
  input  shp_pkg::pix_t      up_i,
  output shp_pkg::pix_t      value_o
);

  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  shp_pkg::pix_t left_q [MAX_CHANNELS];

  logic [AW-1:0]   idx;
  logic [1:0]      rem;
  logic [CHW-1:0]  chan;
  logic [LW:0]     idx_w;
  logic [LW:0]     chans_w;
  logic            border;
  logic signed [11:0] sum;

  // Remainder by three through a reciprocal multiply, exact below 2^16.
  function automatic logic [1:0] rem3(input logic [15:0] n);
    logic [31:0] p;
    logic [15:0] q;
    logic [17:0] t;
    p = 32'(n) * 32'd43691;
    q = 16'(p >> 17);
    t = 18'(q) * 18'd3;
    return 2'(18'(n) - t);
  endfunction

  assign idx = AW'(ctl_i.idx);

  always_comb begin
    if (32'(chans_i) == 32'd2) begin
      rem = {1'b0, idx[0]};
    end else if (32'(chans_i) == 32'd3) begin
      rem = rem3(ctl_i.idx);
    end else if (32'(chans_i) == 32'd4) begin
      rem = idx[1:0];
    end else begin
      rem = 2'd0;
    end
  end

  assign chan    = CHW'(rem);
  assign idx_w   = (LW+1)'(idx);
  assign chans_w = (LW+1)'(chans_i);
  // First column: index below the channel count; last column: index plus
  // channel count reaches the row length.
  assign border  = (idx_w < chans_w) || ((idx_w + chans_w) >= (LW+1)'(len_i));

  assign sum = 12'sd5 * $signed({4'd0, centre_i})
             - $signed({4'd0, left_q[chan]}) - $signed({4'd0, right_i})
             - $signed({4'd0, up_i}) - $signed({4'd0, pixel_i});

  always_comb begin
    if (border || sum < 12'sd0) begin
      value_o = '0;
    end else if (sum > 12'sd255) begin
      value_o = 8'd255;
    end else begin
      value_o = 8'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_q[i] <= '0;
      end
    end else if (ctl_i.step) begin
      left_q[chan] <= centre_i;
    end
  end

endmodule

// ===== rtl/core/sharpen_3x3_stream_top.sv =====
// Top level of the streaming 3x3 cross sharpening filter with two line stores.
//
// Channel  Direction  Handshake                     Payload
// s_axis   in         s_axis_tvalid/s_axis_tready   tdata: pixel_byte; tuser: frame_start
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata: out_row, out_index, out_value;
//                                                   tlast: run_last
// cfg      in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// An item is accepted every cycle while the input does not stall; its line store
// reads are registered in the kernel stage and its results enter the output register
// when it leaves the kernel stage. Items of the last row give two results and therefore
// hold the output register until both are taken; items of the second row give none.
// Reset clears the position counters and the left neighbour store and loads the
// default configuration; the line stores start undefined. The input stalls only
// when both the kernel stage and the output register are occupied.
module sharpen_3x3_stream_top #(
  parameter int MAX_COLS     = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [11:0] out_row, [24:12] out_index,
                                      // [32:25] out_value, [39:33] zero
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int LINE_DEPTH = MAX_COLS * MAX_CHANNELS;
  localparam int AW         = $clog2(LINE_DEPTH);
  localparam int LW         = $clog2(LINE_DEPTH + 1);
  localparam int CW         = $clog2(MAX_COLS + 1);
  localparam int HW         = $clog2(MAX_CHANNELS + 1);

  // Configuration.
  logic [11:0] cfg_cols_q, cfg_rows_q;
  logic [2:0]  cfg_chans_q;
  logic [CW-1:0] cols_e;
  logic [HW-1:0] chans_e;
  shp_pkg::row_t rows_e;
  logic [LW-1:0] len;

  // Position counters.
  logic [AW-1:0]  k_q;
  shp_pkg::row_t  r_q;
  logic [LW-1:0]  k_base, k_next;
  logic [12:0]    r_base, r_next;
  logic [LW:0]    rb_sum;
  logic [AW-1:0]  rd_a, rd_b;
  shp_pkg::shp_res_e res_kind;

  // Kernel stage.
  logic              s1_valid_q;
  logic [AW-1:0]     s1_k_q;
  shp_pkg::row_t     s1_row_q;
  shp_pkg::pix_t     s1_pix_q;
  shp_pkg::shp_res_e s1_kind_q;
  shp_pkg::pix_t     cen_q, rgt_q, up_q;
  shp_pkg::pix_t     kern_value;
  shp_pkg::shp_kctl_t kctl;

  // Output register with a second pending result for last-row items.
  logic          o_valid_q, o_last_q, pend_q;
  shp_pkg::row_t o_row_q, pend_row_q;
  logic [12:0]   o_index_q;
  shp_pkg::pix_t o_value_q;

  logic accept, o_free, s1_emits, s1_adv;

  shp_pkg::pix_t line_one_up [LINE_DEPTH];
  shp_pkg::pix_t line_two_up [LINE_DEPTH];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q  <= shp_pkg::COLUMNS_RST;
      cfg_rows_q  <= shp_pkg::ROWS_RST;
      cfg_chans_q <= shp_pkg::CHANNELS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        shp_pkg::CFG_COLUMNS:  cfg_cols_q  <= cfg_data_i;
        shp_pkg::CFG_ROWS:     cfg_rows_q  <= cfg_data_i;
        shp_pkg::CFG_CHANNELS: cfg_chans_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_cols_q < shp_pkg::COLS_MIN) begin
      cols_e = CW'(shp_pkg::COLS_MIN);
    end else if (32'(cfg_cols_q) > 32'(MAX_COLS)) begin
      cols_e = CW'(MAX_COLS);
    end else begin
      cols_e = CW'(cfg_cols_q);
    end
    if (cfg_chans_q == 3'd0) begin
      chans_e = HW'(1);
    end else if (32'(cfg_chans_q) > 32'(MAX_CHANNELS)) begin
      chans_e = HW'(MAX_CHANNELS);
    end else begin
      chans_e = HW'(cfg_chans_q);
    end
    rows_e = (cfg_rows_q < shp_pkg::ROWS_MIN) ? shp_pkg::ROWS_MIN : cfg_rows_q;
  end

  assign len = LW'(cols_e * chans_e);

  // Position of the incoming item and of the one after it.
  always_comb begin
    k_base = s_axis_tuser ? '0 : LW'(k_q);
    r_base = s_axis_tuser ? '0 : {1'b0, r_q};
    if (k_base >= len) begin
      k_base = '0;
      r_base = r_base + 13'd1;
    end
    if (r_base >= {1'b0, rows_e}) begin
      r_base = '0;
    end
    k_next = k_base + LW'(1);
    r_next = r_base;
    if (k_next >= len) begin
      k_next = '0;
      r_next = r_base + 13'd1;
      if (r_next >= {1'b0, rows_e}) begin
        r_next = '0;
      end
    end
  end

  always_comb begin
    if (r_base == 13'd0) begin
      res_kind = shp_pkg::RES_ZERO_ROW;
    end else if (r_base == 13'd1) begin
      res_kind = shp_pkg::RES_NONE;
    end else if (r_base == {1'b0, rows_e} - 13'd1) begin
      res_kind = shp_pkg::RES_LAST_ROW;
    end else begin
      res_kind = shp_pkg::RES_BODY;
    end
  end

  assign rd_a   = AW'(k_base);
  assign rb_sum = (LW+1)'(k_base) + (LW+1)'(chans_e);
  // The right neighbour beyond the store only occurs in the last column.
  assign rd_b   = (rb_sum >= (LW+1)'(LINE_DEPTH)) ? '0 : AW'(rb_sum);

  // Handshake between stages.
  assign s1_emits      = (s1_kind_q != shp_pkg::RES_NONE);
  assign o_free        = !o_valid_q || (m_axis_tready && !pend_q);
  assign s1_adv        = s1_valid_q && (!s1_emits || o_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      r_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        k_q        <= AW'(k_next);
        r_q        <= shp_pkg::row_t'(r_next);
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_k_q    <= rd_a;
      s1_row_q  <= shp_pkg::row_t'(r_base);
      s1_pix_q  <= s_axis_tdata;
      s1_kind_q <= res_kind;
    end
  end

  // Line store of the previous row: centre and right neighbour are read
  // before the new component takes the centre's place.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cen_q <= line_one_up[rd_a];
      rgt_q <= line_one_up[rd_b];
      line_one_up[rd_a] <= s_axis_tdata;
    end
  end

  // Line store of the row two up: written when the item leaves the kernel.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_q <= line_two_up[rd_a];
    end
    if (s1_adv) begin
      line_two_up[s1_k_q] <= cen_q;
    end
  end

  assign kctl.step = s1_adv;
  assign kctl.idx  = 16'(s1_k_q);

  shp_kernel #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW),
    .LW           (LW),
    .HW           (HW)
  ) u_kernel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (kctl),
    .len_i    (len),
    .chans_i  (chans_e),
    .pixel_i  (s1_pix_q),
    .centre_i (cen_q),
    .right_i  (rgt_q),
    .up_i     (up_q),
    .value_o  (kern_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      pend_q    <= 1'b0;
    end else if (s1_adv && s1_emits) begin
      o_valid_q <= 1'b1;
      pend_q    <= (s1_kind_q == shp_pkg::RES_LAST_ROW);
    end else if (o_valid_q && m_axis_tready) begin
      o_valid_q <= pend_q;
      pend_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emits) begin
      o_index_q  <= 13'(s1_k_q);
      pend_row_q <= s1_row_q;
      case (s1_kind_q)
        shp_pkg::RES_ZERO_ROW: begin
          o_row_q   <= '0;
          o_value_q <= '0;
          o_last_q  <= 1'b1;
        end
        shp_pkg::RES_LAST_ROW: begin
          o_row_q   <= s1_row_q - 12'd1;
          o_value_q <= kern_value;
          o_last_q  <= 1'b0;
        end
        default: begin
          o_row_q   <= s1_row_q - 12'd1;
          o_value_q <= kern_value;
          o_last_q  <= 1'b1;
        end
      endcase
    end else if (o_valid_q && m_axis_tready && pend_q) begin
      // Zero border result of the last row follows the sharpened one.
      o_row_q   <= pend_row_q;
      o_value_q <= '0;
      o_last_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {7'd0, o_value_q, o_index_q, o_row_q};

  // A pending second result only exists behind a shown first result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> o_valid_q)
    else $error("pending result without a valid output");

  // The first of a pair of results never closes the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> !o_last_q)
    else $error("first of two results marked last");

  // Taking a single result with nothing arriving leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && m_axis_tready && !pend_q && !(s1_adv && s1_emits)) |=> !o_valid_q)
    else $error("output valid without a source");

  // A stalled kernel stage keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_k_q)))
    else $error("kernel stage item lost while stalled");

endmodule
